[rtl/core/trn_pkg.sv]
// Package with telnet byte codes, parser state type and decode result type.
package trn_pkg;

   // Telnet command bytes
   localparam logic [7:0] B_IAC  = 8'd255;
   localparam logic [7:0] B_DONT = 8'd254;
   localparam logic [7:0] B_DO   = 8'd253;
   localparam logic [7:0] B_WONT = 8'd252;
   localparam logic [7:0] B_WILL = 8'd251;
   localparam logic [7:0] B_SB   = 8'd250;
   localparam logic [7:0] B_SE   = 8'd240;
   localparam logic [7:0] B_NOP  = 8'd241;
   localparam logic [7:0] B_AYT  = 8'd246;

   // Option codes that the policy accepts
   localparam logic [7:0] OPT_ECHO = 8'd1;
   localparam logic [7:0] OPT_SGA  = 8'd3;

   // Parser states, one-hot
   typedef enum logic [7:0] {
      ST_DATA   = 8'b0000_0001,
      ST_IAC    = 8'b0000_0010,
      ST_WILL   = 8'b0000_0100,
      ST_WONT   = 8'b0000_1000,
      ST_DO     = 8'b0001_0000,
      ST_DONT   = 8'b0010_0000,
      ST_SB     = 8'b0100_0000,
      ST_SB_IAC = 8'b1000_0000
   } state_type;

   // What one received byte causes
   typedef struct packed {
      state_type  next_state;
      logic       next_echo;
      logic [1:0] count;     // number of result items, 0..3
      logic       to_peer;   // all results of one byte share the direction
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
   } decode_type;

endpackage

[rtl/core/trn_decode.sv]
// Combinational telnet parser step: next state, echo flag and result bytes.
module trn_decode (
   input  trn_pkg::state_type  state,
   input  logic                echo,
   input  logic [7:0]          rx_byte,
   output trn_pkg::decode_type dec
);

   logic is_echo;
   logic is_sga;

   assign is_echo = (rx_byte == trn_pkg::OPT_ECHO);
   assign is_sga  = (rx_byte == trn_pkg::OPT_SGA);

   // Per-state decode
   always_comb begin
      dec            = '0;
      dec.next_state = trn_pkg::ST_DATA;
      dec.next_echo  = echo;
      dec.byte0      = trn_pkg::B_IAC;
      dec.byte1      = 8'd0;
      dec.byte2      = rx_byte;
      unique case (state)
         trn_pkg::ST_DATA: begin
            if (rx_byte == trn_pkg::B_IAC) begin
               dec.next_state = trn_pkg::ST_IAC;
            end else begin
               dec.count = 2'd1;
               dec.byte0 = rx_byte;
            end
         end
         trn_pkg::ST_IAC: begin
            case (rx_byte)
               trn_pkg::B_IAC: begin
                  dec.count = 2'd1;
                  dec.byte0 = rx_byte;
               end
               trn_pkg::B_WILL: dec.next_state = trn_pkg::ST_WILL;
               trn_pkg::B_WONT: dec.next_state = trn_pkg::ST_WONT;
               trn_pkg::B_DO:   dec.next_state = trn_pkg::ST_DO;
               trn_pkg::B_DONT: dec.next_state = trn_pkg::ST_DONT;
               trn_pkg::B_SB:   dec.next_state = trn_pkg::ST_SB;
               trn_pkg::B_AYT: begin
                  // are-you-there gets IAC NOP
                  dec.count   = 2'd2;
                  dec.to_peer = 1'b1;
                  dec.byte1   = trn_pkg::B_NOP;
               end
               default: ;  // other commands dropped
            endcase
         end
         trn_pkg::ST_WILL: begin
            dec.count   = 2'd3;
            dec.to_peer = 1'b1;
            dec.byte1   = (is_echo || is_sga) ? trn_pkg::B_DO : trn_pkg::B_DONT;
            if (is_echo) dec.next_echo = 1'b0;
         end
         trn_pkg::ST_WONT: begin
            dec.count   = 2'd3;
            dec.to_peer = 1'b1;
            dec.byte1   = trn_pkg::B_DONT;
            if (is_echo) dec.next_echo = 1'b1;
         end
         trn_pkg::ST_DO: begin
            dec.count   = 2'd3;
            dec.to_peer = 1'b1;
            dec.byte1   = (is_echo || is_sga) ? trn_pkg::B_WILL : trn_pkg::B_WONT;
            if (is_echo) dec.next_echo = 1'b1;
         end
         trn_pkg::ST_DONT: begin
            dec.count   = 2'd3;
            dec.to_peer = 1'b1;
            dec.byte1   = trn_pkg::B_WONT;
            if (is_echo) dec.next_echo = 1'b0;
         end
         trn_pkg::ST_SB: begin
            dec.next_state = (rx_byte == trn_pkg::B_IAC) ? trn_pkg::ST_SB_IAC
                                                         : trn_pkg::ST_SB;
         end
         trn_pkg::ST_SB_IAC: begin
            // escaped IAC keeps skipping; SE or anything else ends it
            dec.next_state = (rx_byte == trn_pkg::B_IAC) ? trn_pkg::ST_SB
                                                         : trn_pkg::ST_DATA;
         end
         default: dec.next_state = trn_pkg::ST_DATA;
      endcase
   end

endmodule

[rtl/core/telnet_receive_negotiator_unit.sv]
// Top level of the telnet receive negotiator: parser state and result buffer.
// Takes one received telnet byte per item and emits display bytes and option
// replies. A byte that yields no result or one result is accepted every cycle
// while rsp_ready is high, also while the previous result is being taken. An
// IAC AYT or a WILL/WONT/DO/DONT option byte holds the input until its last
// reply leaves, as the buffer hands out one reply byte per cycle while rsp_ready
// is high. Results are offered from the cycle after their item is accepted.
module telnet_receive_negotiator_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_to_peer,
   output logic       rsp_last_of_run,
   output logic       rsp_echo_on
);

   trn_pkg::state_type  state_ff, state_in;
   logic                echo_ff, echo_in;
   logic [1:0]          rem_ff, rem_in;   // results still to hand out
   logic [1:0]          sel_ff, sel_in;   // which buffered byte is current
   logic [7:0]          byte0_ff, byte1_ff, byte2_ff;
   logic                peer_ff;
   trn_pkg::decode_type dec;
   logic                req_take;
   logic                rsp_take;

   trn_decode u_decode (
      .state   (state_ff),
      .echo    (echo_ff),
      .rx_byte (req_rx_byte),
      .dec     (dec)
   );

   // Handshakes: a new item may enter as the last buffered result leaves
   assign rsp_valid = (rem_ff != 2'd0);
   assign rsp_take  = rsp_valid && rsp_ready;
   assign req_ready = (rem_ff == 2'd0) || ((rem_ff == 2'd1) && rsp_ready);
   assign req_take  = req_valid && req_ready;

   // Result fields
   always_comb begin
      case (sel_ff)
         2'd0:    rsp_out_byte = byte0_ff;
         2'd1:    rsp_out_byte = byte1_ff;
         default: rsp_out_byte = byte2_ff;
      endcase
   end
   assign rsp_to_peer     = peer_ff;
   assign rsp_last_of_run = (rem_ff == 2'd1);
   assign rsp_echo_on     = echo_ff;

   // Next-state logic
   always_comb begin
      state_in = state_ff;
      echo_in  = echo_ff;
      rem_in   = rem_ff;
      sel_in   = sel_ff;
      if (req_take) begin
         state_in = dec.next_state;
         echo_in  = dec.next_echo;
         rem_in   = dec.count;
         sel_in   = 2'd0;
      end else if (rsp_take) begin
         rem_in = rem_ff - 2'd1;
         sel_in = sel_ff + 2'd1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= trn_pkg::ST_DATA;
         echo_ff  <= 1'b1;
         rem_ff   <= 2'd0;
         sel_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         echo_ff  <= echo_in;
         rem_ff   <= rem_in;
         sel_ff   <= sel_in;
      end
   end

   // Result payload, loaded when an item is accepted
   always_ff @(posedge clock) begin
      if (req_take) begin
         byte0_ff <= dec.byte0;
         byte1_ff <= dec.byte1;
         byte2_ff <= dec.byte2;
         peer_ff  <= dec.to_peer;
      end
   end

endmodule
